### rtl/core/skbs_pkg.sv
// Shared constants and control types for the sorted key bound search core.
`timescale 1ns / 1ps

package skbs_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int POS_W       = 9;
	localparam int KEY_W       = 32;
	localparam int ACT_W       = 2;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FIRST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LAST  = 2'd2;

	typedef struct packed {
		logic write;
		logic load;
		logic probe;
		logic update;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic range_empty;
	} status_t;

endpackage

### rtl/core/skbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module skbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/skbs_ctrl.sv
// Controller state machine that sequences the probes of one search request.
`timescale 1ns / 1ps

module skbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [skbs_pkg::ACT_W-1:0]    action,
	input  skbs_pkg::status_t             status,
	output skbs_pkg::cmd_t                cmd,
	output logic                          busy,
	output logic                          done
);

	import skbs_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_PROBE   = 2'd1;
	localparam logic [1:0] ST_COMPARE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       accept;
	logic       is_search;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	always_comb begin
		is_search = 1'b0;
		case (action) inside
			ACT_FIRST, ACT_LAST: is_search = 1'b1;
			default:             is_search = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.write  = accept && (action == ACT_WRITE);
		cmd.load   = accept && is_search;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (status.range_empty) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.probe = 1'b1;
					state_d   = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				cmd.update = 1'b1;
				state_d    = ST_PROBE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_PROBE)
		else $error("result strobe without a finishing probe state");

	a_compare_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPARE |=> state_q == ST_PROBE)
		else $error("compare state did not return to probe");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_PROBE)
		else $error("accepted search did not enter probe state");

	a_no_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.write && !cmd.load)
		else $error("request taken while busy");

endmodule

### rtl/core/skbs_dp.sv
// Datapath with key store, search bounds, midpoint and key compare.
`timescale 1ns / 1ps

module skbs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skbs_pkg::cmd_t                cmd,
	input  logic [skbs_pkg::ACT_W-1:0]    action,
	input  logic [skbs_pkg::POS_W-1:0]    slot,
	input  logic [skbs_pkg::KEY_W-1:0]    key_value,
	input  logic                          entry_count_wr_en,
	input  logic [skbs_pkg::POS_W-1:0]    entry_count,
	output skbs_pkg::status_t             status,
	output logic [skbs_pkg::POS_W-1:0]    position
);

	import skbs_pkg::*;

	logic [POS_W-1:0]  count_q;
	logic [POS_W-1:0]  live_count;
	logic [POS_W-1:0]  lo_q;
	logic [POS_W-1:0]  hi_q;
	logic [POS_W-1:0]  mid_q;
	logic [POS_W-1:0]  mid;
	logic [POS_W:0]    mid_sum;
	logic [POS_W-1:0]  position_q;
	logic [KEY_W-1:0]  key_q;
	logic              last_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [POS_W-1:0]  rd_pos;
	logic [POS_W-1:0]  wr_pos;
	logic [KEY_W-1:0]  rd_data;

	assign live_count = (count_q > POS_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : count_q;

	assign wr_en   = cmd.write && (slot != '0) && (slot <= POS_W'(MAX_ENTRIES));
	assign wr_pos  = slot - POS_W'(1);
	assign wr_addr = wr_pos[ADDR_W-1:0];

	assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q} + {{POS_W{1'b0}}, last_q};
	assign mid     = mid_sum[POS_W:1];
	assign rd_pos  = mid - POS_W'(1);
	assign rd_addr = rd_pos[ADDR_W-1:0];

	assign status.range_empty = !(hi_q > lo_q);
	assign position           = position_q;

	skbs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_ENTRIES)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(key_value),
		.rd_en  (cmd.probe),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (entry_count_wr_en) begin
			count_q <= entry_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key_value;
			last_q <= (action == ACT_LAST);
			if (action == ACT_LAST) begin
				lo_q <= '0;
				hi_q <= live_count;
			end else begin
				lo_q <= POS_W'(1);
				hi_q <= live_count + POS_W'(1);
			end
		end else if (cmd.update) begin
			if (last_q) begin
				if (rd_data > key_q) begin
					hi_q <= mid_q - POS_W'(1);
				end else begin
					lo_q <= mid_q;
				end
			end else begin
				if (rd_data < key_q) begin
					lo_q <= mid_q + POS_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.finish) begin
			position_q <= lo_q;
		end
	end

	a_update_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.probe))
		else $error("bound update without a preceding key read");

	a_first_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !last_q |=> position_q != '0)
		else $error("first-not-below search reported slot zero");

endmodule

### rtl/core/sorted_key_bound_search_core.sv
// A write request takes effect at its accept edge and gives no result.
// A search request probes the key RAM k times, k at most 9 for 256 entries; each probe
// is a key read in the probe state and a bound update in the compare state.
// No new request is taken while busy; each probe address depends on the last compare.
// The receiver cannot stall; position is valid only in the cycle that done is high.
// Reset clears the entry count and the controller; key slots are undefined until written.
`timescale 1ns / 1ps

module sorted_key_bound_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [skbs_pkg::ACT_W-1:0]    action,
	input  logic [skbs_pkg::POS_W-1:0]    slot,
	input  logic [skbs_pkg::KEY_W-1:0]    key_value,
	input  logic                          entry_count_wr_en,
	input  logic [skbs_pkg::POS_W-1:0]    entry_count,
	output logic                          done,
	output logic [skbs_pkg::POS_W-1:0]    position
);

	import skbs_pkg::*;

	cmd_t    cmd;
	status_t status;

	skbs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	skbs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.action           (action),
		.slot             (slot),
		.key_value        (key_value),
		.entry_count_wr_en(entry_count_wr_en),
		.entry_count      (entry_count),
		.status           (status),
		.position         (position)
	);

endmodule

### tb/sv/sorted_key_bound_search_core_tb.sv
// Self-checking testbench for the sorted key bound search core, with a table-driven and a random part.
`timescale 1ns / 1ps

module sorted_key_bound_search_core_tb;
	import skbs_pkg::*;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 4000;
	localparam int ITEM_TARGET   = 1500;
	localparam int PHASE_ITEMS   = 110;

	typedef enum bit {ROW_REQUEST, ROW_COUNT} row_kind_t;
	typedef enum int {FILL_SPREAD, FILL_DUPLICATES, FILL_FULL_RANGE} fill_style_t;

	// For a count row the slot column carries the new entry count.
	typedef struct {
		row_kind_t        kind;
		logic [ACT_W-1:0] act;
		bit [POS_W-1:0]   slot;
		bit [KEY_W-1:0]   key;
		bit               typed;
		bit [POS_W-1:0]   want;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] slot;
	logic [KEY_W-1:0] key_value;
	logic             entry_count_wr_en;
	logic [POS_W-1:0] entry_count;
	logic             done;
	logic [POS_W-1:0] position;

	bit [KEY_W-1:0] key_mem [1:MAX_ENTRIES];
	bit [POS_W-1:0] count_setting;
	bit [POS_W-1:0] pending_pos [$];
	bit [POS_W-1:0] head_pos;
	stim_row_t      script [$];
	int             idle_pct;
	int             fail_count;
	int             stall_cycles;
	int             items_done;
	int             searches_done;
	int             writes_done;
	int             ignored_done;
	int             positions_checked;
	int             settings_used;

	sorted_key_bound_search_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.slot(slot),
		.key_value(key_value),
		.entry_count_wr_en(entry_count_wr_en),
		.entry_count(entry_count),
		.done(done),
		.position(position)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int live_entries();
		return (count_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_setting);
	endfunction

	function automatic bit [POS_W-1:0] lower_bound_slot(bit [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 1;
		hi = live_entries() + 1;
		while (hi > lo) begin
			mid = (hi + lo) / 2;
			if (key_mem[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		return POS_W'(lo);
	endfunction

	function automatic bit [POS_W-1:0] upper_bound_slot(bit [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = live_entries();
		while (hi > lo) begin
			mid = (hi + lo + 1) / 2;
			if (key_mem[mid] > k)
				hi = mid - 1;
			else
				lo = mid;
		end
		return POS_W'(lo);
	endfunction

	function automatic bit [KEY_W-1:0] search_key();
		bit [KEY_W-1:0] base;
		base = key_mem[$urandom_range(1, MAX_ENTRIES)];
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			4: return base - 1;
			5: return base + 1;
			default: return base;
		endcase
	endfunction

	task automatic issue_request(logic [ACT_W-1:0] act, bit [POS_W-1:0] s, bit [KEY_W-1:0] k,
			bit typed, bit [POS_W-1:0] want);
		if ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
		start     = 1'b1;
		action    = act;
		slot      = s;
		key_value = k;
		do @(posedge clk); while (busy !== 1'b0);
		case (act)
			ACT_WRITE: begin
				if (s >= 1 && s <= MAX_ENTRIES) begin
					key_mem[s] = k;
					writes_done++;
					items_done++;
				end else begin
					ignored_done++;
				end
			end
			ACT_FIRST: begin
				pending_pos.push_back(typed ? want : lower_bound_slot(k));
				searches_done++;
				items_done++;
			end
			ACT_LAST: begin
				pending_pos.push_back(typed ? want : upper_bound_slot(k));
				searches_done++;
				items_done++;
			end
			default: begin
				ignored_done++;
			end
		endcase
		@(negedge clk);
	endtask

	// Writes give no result, so a settle time follows the last search result.
	task automatic wait_idle();
		start = 1'b0;
		while (pending_pos.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_count(bit [POS_W-1:0] n);
		wait_idle();
		entry_count_wr_en = 1'b1;
		entry_count       = n;
		@(negedge clk);
		entry_count_wr_en = 1'b0;
		count_setting     = n;
		settings_used++;
	endtask

	task automatic fill_store(fill_style_t style);
		bit [KEY_W-1:0] k;
		k = '0;
		for (int s = 1; s <= MAX_ENTRIES; s++) begin
			case (style)
				FILL_SPREAD: begin
					k = (s == 1) ? 32'd0 : k + $urandom_range(1, 16000000);
				end
				FILL_DUPLICATES: begin
					k = 32'd5000 * (s / 8) + 32'd7;
				end
				default: begin
					k = (s == MAX_ENTRIES) ? '1 : 32'(s - 1) * 32'd16843009;
				end
			endcase
			issue_request(ACT_WRITE, POS_W'(s), k, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_pos.size() == 0) begin
				$display("%0t: position %0d arrived with no search pending", $time, position);
				fail_count++;
			end else begin
				head_pos = pending_pos.pop_front();
				positions_checked++;
				if (position !== head_pos) begin
					$display("%0t: position mismatch, expected %0d, actual %0d",
						$time, head_pos, position);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int             p;
		int unsigned    r;
		bit [POS_W-1:0] s_pick;
		bit [POS_W-1:0] n_count;
		bit [KEY_W-1:0] k;
		bit [KEY_W-1:0] lo_k;
		bit [KEY_W-1:0] hi_k;
		int             idle_levels [3];

		arst_n            = 1'b0;
		start             = 1'b0;
		action            = ACT_WRITE;
		slot              = '0;
		key_value         = '0;
		entry_count_wr_en = 1'b0;
		entry_count       = '0;
		idle_pct          = 0;
		idle_levels       = '{0, 74, 12};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		script.push_back('{ROW_REQUEST, ACT_FIRST, 9'd0,   32'h0000_0000, 1'b1, 9'd1});
		script.push_back('{ROW_REQUEST, ACT_LAST,  9'd0,   32'hFFFF_FFFF, 1'b1, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd0,   32'h0000_0005, 1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd511, 32'h0000_0005, 1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_NONE,  9'd1,   32'hFFFF_FFFF, 1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd1,   32'h0000_0000, 1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd2,   32'd100,       1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd3,   32'd200,       1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_WRITE, 9'd256, 32'hFFFF_FFFF, 1'b0, 9'd0});
		script.push_back('{ROW_COUNT,   ACT_NONE,  9'd3,   32'd0,         1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_FIRST, 9'd0,   32'h0000_0000, 1'b1, 9'd1});
		script.push_back('{ROW_REQUEST, ACT_FIRST, 9'd0,   32'd100,       1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_FIRST, 9'd0,   32'd101,       1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_FIRST, 9'd511, 32'hFFFF_FFFF, 1'b1, 9'd4});
		script.push_back('{ROW_REQUEST, ACT_LAST,  9'd0,   32'h0000_0000, 1'b1, 9'd1});
		script.push_back('{ROW_REQUEST, ACT_LAST,  9'd0,   32'd99,        1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_LAST,  9'd0,   32'd200,       1'b0, 9'd0});
		script.push_back('{ROW_REQUEST, ACT_LAST,  9'd511, 32'hFFFF_FFFF, 1'b1, 9'd3});
		script.push_back('{ROW_REQUEST, ACT_NONE,  9'd0,   32'h0000_0000, 1'b0, 9'd0});

		foreach (script[i]) begin
			if (script[i].kind == ROW_COUNT)
				set_count(script[i].slot);
			else
				issue_request(script[i].act, script[i].slot, script[i].key,
					script[i].typed, script[i].want);
		end

		p = 0;
		while (items_done < ITEM_TARGET) begin
			idle_pct = idle_levels[p % 3];
			if (p % 3 == 0)
				fill_store(fill_style_t'((p / 3) % 3));
			case (p % 8)
				0: n_count = 9'd256;
				1: n_count = 9'd511;
				2: n_count = 9'd0;
				3: n_count = 9'd1;
				4: n_count = POS_W'($urandom_range(257, 510));
				5: n_count = 9'd2;
				default: n_count = POS_W'($urandom_range(3, 255));
			endcase
			set_count(n_count);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 49) == 0)
					wait_idle();
				if (r < 55) begin
					issue_request(r[0] ? ACT_FIRST : ACT_LAST, POS_W'($urandom()),
						search_key(), 1'b0, '0);
				end else if (r < 85) begin
					s_pick = POS_W'($urandom_range(1, MAX_ENTRIES));
					lo_k = (s_pick == 1) ? '0 : key_mem[s_pick - 1];
					hi_k = (s_pick == MAX_ENTRIES) ? '1 : key_mem[s_pick + 1];
					if (lo_k <= hi_k && $urandom_range(0, 9) != 0)
						k = lo_k + $urandom_range(0, hi_k - lo_k);
					else
						k = $urandom();
					issue_request(ACT_WRITE, s_pick, k, 1'b0, '0);
				end else if (r < 93) begin
					s_pick = r[0] ? 9'd0 : POS_W'($urandom_range(257, 511));
					issue_request(ACT_WRITE, s_pick, $urandom(), 1'b0, '0);
				end else begin
					issue_request(ACT_NONE, POS_W'($urandom()), $urandom(), 1'b0, '0);
				end
			end
			p++;
		end

		wait_idle();
		$display("Run covered %0d searches and %0d key writes under %0d entry count settings.",
			searches_done, writes_done, settings_used);
		$display("%0d positions checked, %0d ignored requests sent, %0d mismatches.",
			positions_checked, ignored_done, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
